// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gpe_pkg.sv =====
package gpe_pkg;

  localparam int NUM_GEARS  = 6;
  localparam int GEAR_SLOTS = 6;

  localparam int TIRE_W   = 12;
  localparam int RREG_W   = 16;
  localparam int RPM_W    = 14;
  localparam int KMH_W    = 8;
  localparam int GEAR_W   = 3;
  localparam int RATIO_W  = 20;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
  localparam int DATA_W   = 32;

  localparam int PROD1_W    = TIRE_W + RPM_W;
  localparam int NUM_W      = 32;
  localparam int DEN0_W     = KMH_W + RREG_W;
  localparam int DEN_W      = 44;
  localparam int FRAC_SHIFT = 24;
  localparam int REM_W      = NUM_W + FRAC_SHIFT;
  localparam int DIV_STEPS  = RATIO_W;
  localparam int DS_W       = DEN_W + DIV_STEPS - 1;
  localparam int SAT_W      = DEN_W + RATIO_W;
  localparam int ERR_W      = RATIO_W + 1;

  localparam int RPM_SCALE = 60;
  localparam int DEN_SCALE = 1000000;

  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
  localparam logic [ERR_W-1:0]   ERR_INIT  = {ERR_W{1'b1}};

  localparam logic [$clog2(NUM_REGS)-1:0] REG_TIRE       = 3'd0;
  localparam logic [$clog2(NUM_REGS)-1:0] REG_FDR        = 3'd1;
  localparam logic [$clog2(NUM_REGS)-1:0] REG_GEAR_FIRST = 3'd2;

  localparam logic [TIRE_W-1:0] TIRE_RESET = 12'd2044;
  localparam logic [RREG_W-1:0] FDR_RESET  = 16'd15581;
  localparam logic [GEAR_SLOTS-1:0][RREG_W-1:0] GEAR_RESET =
    {16'd2458, 16'd2896, 16'd4096, 16'd5935, 16'd8159, 16'd14283};

  typedef logic [RREG_W-1:0] rreg_t;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [DS_W-1:0]    ds;
    logic [RATIO_W-1:0] quot;
    logic               sat;
    logic               stand;
  } div_word_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [ERR_W-1:0]   best_err;
    logic [GEAR_W-1:0]  best_gear;
    logic               stand;
  } gear_word_t;

endpackage

// ===== rtl/gpe_if.sv =====
interface gpe_sample_if;
  logic                        valid;
  logic                        ready;
  logic [gpe_pkg::RPM_W-1:0]   engine_rpm;
  logic [gpe_pkg::KMH_W-1:0]   speed_kmh;

  modport source (output valid, engine_rpm, speed_kmh, input ready);
  modport sink (input valid, engine_rpm, speed_kmh, output ready);
endinterface

interface gpe_result_if;
  logic                        valid;
  logic                        ready;
  logic [gpe_pkg::GEAR_W-1:0]  gear;
  logic [gpe_pkg::RATIO_W-1:0] measured_ratio;

  modport source (output valid, gear, measured_ratio, input ready);
  modport sink (input valid, gear, measured_ratio, output ready);
endinterface

// ===== rtl/gpe_div_cell.sv =====
`include "assert_macros.svh"

module gpe_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  output logic               ready_out,
  input  gpe_pkg::div_word_t data_in,
  output logic               valid_out,
  input  logic               ready_in,
  output gpe_pkg::div_word_t data_out
);

  logic               take;
  gpe_pkg::div_word_t data_next;

  assign ready_out = !valid_out || ready_in;
  assign take = gpe_pkg::DS_W'(data_in.rem) >= data_in.ds;

  always_comb begin
    data_next       = data_in;
    data_next.rem   = take ? data_in.rem - data_in.ds[gpe_pkg::REM_W-1:0] : data_in.rem;
    data_next.ds    = data_in.ds >> 1;
    data_next.quot  = {data_in.quot[gpe_pkg::RATIO_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ready_out) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_out <= data_next;
    end
  end

  // unsaturated remainder stays below twice the current divisor
  `ASSERT_IMPLIES(a_rem_bound, clk, rst, valid_in && !data_in.sat,
    {1'b0, gpe_pkg::DS_W'(data_in.rem)} < {data_in.ds, 1'b0})

endmodule

// ===== rtl/gpe_gear_cell.sv =====
`include "assert_macros.svh"

module gpe_gear_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  gpe_pkg::rreg_t             gear_ratio,
  input  logic [gpe_pkg::GEAR_W-1:0] gear_num,
  input  logic                       valid_in,
  output logic                       ready_out,
  input  gpe_pkg::gear_word_t        data_in,
  output logic                       valid_out,
  input  logic                       ready_in,
  output gpe_pkg::gear_word_t        data_out
);

  logic [gpe_pkg::RATIO_W-1:0] g_ext;
  logic [gpe_pkg::ERR_W-1:0]   err;
  gpe_pkg::gear_word_t         data_next;

  assign ready_out = !valid_out || ready_in;
  assign g_ext = gpe_pkg::RATIO_W'(gear_ratio);
  assign err = (g_ext > data_in.ratio) ? gpe_pkg::ERR_W'(g_ext - data_in.ratio)
                                       : gpe_pkg::ERR_W'(data_in.ratio - g_ext);

  // strict compare keeps the lower gear on a tie
  always_comb begin
    data_next = data_in;
    if (err < data_in.best_err) begin
      data_next.best_err  = err;
      data_next.best_gear = gear_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ready_out) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      data_out <= data_next;
    end
  end

  `ASSERT_NEXT(a_err_monotonic, clk, rst, valid_in && ready_out,
    valid_out && data_out.best_err <= $past(data_in.best_err))

endmodule

// ===== rtl/gear_position_estimator_top.sv =====
// Gear position estimator: each sample (engine_rpm, speed_kmh) yields one result with
// the overall ratio tire * rpm * 60 / (speed * final_drive * 1e6) as unsigned Q8.12,
// truncated and saturated, and the nearest configured gear (lower gear wins ties).
// Zero speed gives gear 1 and ratio 0. One sample is taken per clock when the result
// side is ready; the pipe holds two multiply stages and a setup stage,
// 20 restoring-division cells (one quotient bit each) and one compare cell per gear.
// Every stage is a valid/ready register, so bubbles are squeezed out under stall.
// Registers sit on the APB port at 4*index; write them only while idle (the block does not enforce it).
`include "assert_macros.svh"

module gear_position_estimator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpe_pkg::ADDR_W-1:0]  paddr,
  input  logic [gpe_pkg::DATA_W-1:0]  pwdata,
  output logic [gpe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  gpe_sample_if.sink                  sample,
  gpe_result_if.source                result
);

  localparam int NG = gpe_pkg::NUM_GEARS;
  localparam int NS = gpe_pkg::DIV_STEPS;

  logic [gpe_pkg::TIRE_W-1:0] tire;
  gpe_pkg::rreg_t             fdr;
  gpe_pkg::rreg_t             gear_ratio [gpe_pkg::GEAR_SLOTS];

  logic [$clog2(gpe_pkg::NUM_REGS)-1:0] reg_idx;
  logic [$clog2(gpe_pkg::NUM_REGS)-1:0] slot;
  logic                                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[gpe_pkg::ADDR_W-1:2];
  assign slot    = reg_idx - gpe_pkg::REG_GEAR_FIRST;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tire <= gpe_pkg::TIRE_RESET;
      fdr  <= gpe_pkg::FDR_RESET;
      for (int i = 0; i < gpe_pkg::GEAR_SLOTS; i++) begin
        gear_ratio[i] <= gpe_pkg::GEAR_RESET[i];
      end
    end else if (wr_en) begin
      case (reg_idx)
        gpe_pkg::REG_TIRE: tire <= pwdata[gpe_pkg::TIRE_W-1:0];
        gpe_pkg::REG_FDR:  fdr  <= pwdata[gpe_pkg::RREG_W-1:0];
        default: begin
          gear_ratio[slot] <= pwdata[gpe_pkg::RREG_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gpe_pkg::REG_TIRE: prdata = gpe_pkg::DATA_W'(tire);
      gpe_pkg::REG_FDR:  prdata = gpe_pkg::DATA_W'(fdr);
      default:           prdata = gpe_pkg::DATA_W'(gear_ratio[slot]);
    endcase
  end

  // front end: products, scaling, divider setup
  logic                        v1, v2, r1, r2, r3;
  logic [gpe_pkg::PROD1_W-1:0] p1;
  logic [gpe_pkg::DEN0_W-1:0]  p2;
  logic                        stand1, stand2;
  logic [gpe_pkg::NUM_W-1:0]   num;
  logic [gpe_pkg::DEN_W-1:0]   den;

  gpe_pkg::div_word_t  div_data  [NS+1];
  logic                div_valid [NS+1];
  logic                div_ready [NS+1];
  gpe_pkg::gear_word_t gear_data  [NG+1];
  logic                gear_valid [NG+1];
  logic                gear_ready [NG+1];

  assign r3 = !div_valid[0] || div_ready[0];
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign sample.ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      div_valid[0] <= 1'b0;
    end else begin
      if (r1) v1 <= sample.valid;
      if (r2) v2 <= v1;
      if (r3) div_valid[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && sample.valid) begin
      p1     <= gpe_pkg::PROD1_W'(tire) * gpe_pkg::PROD1_W'(sample.engine_rpm);
      p2     <= gpe_pkg::DEN0_W'(sample.speed_kmh) * gpe_pkg::DEN0_W'(fdr);
      stand1 <= sample.speed_kmh == '0;
    end
    if (r2 && v1) begin
      num    <= gpe_pkg::NUM_W'(p1) * gpe_pkg::NUM_W'(gpe_pkg::RPM_SCALE);
      den    <= gpe_pkg::DEN_W'(p2) * gpe_pkg::DEN_W'(gpe_pkg::DEN_SCALE);
      stand2 <= stand1;
    end
    if (r3 && v2) begin
      div_data[0].rem   <= {num, {gpe_pkg::FRAC_SHIFT{1'b0}}};
      div_data[0].ds    <= {den, {(NS-1){1'b0}}};
      div_data[0].quot  <= '0;
      div_data[0].sat   <= gpe_pkg::SAT_W'({num, {gpe_pkg::FRAC_SHIFT{1'b0}}})
                           >= {den, {gpe_pkg::RATIO_W{1'b0}}};
      div_data[0].stand <= stand2;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_div
    gpe_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (div_valid[i]),
      .ready_out (div_ready[i]),
      .data_in   (div_data[i]),
      .valid_out (div_valid[i+1]),
      .ready_in  (div_ready[i+1]),
      .data_out  (div_data[i+1])
    );
  end

  assign gear_valid[0]       = div_valid[NS];
  assign div_ready[NS]       = gear_ready[0];
  assign gear_data[0].ratio  = div_data[NS].stand ? '0 :
                               div_data[NS].sat ? gpe_pkg::RATIO_MAX : div_data[NS].quot;
  assign gear_data[0].best_err  = gpe_pkg::ERR_INIT;
  assign gear_data[0].best_gear = gpe_pkg::GEAR_W'(1);
  assign gear_data[0].stand     = div_data[NS].stand;

  for (genvar i = 0; i < NG; i++) begin : g_gear
    gpe_gear_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .gear_ratio (gear_ratio[i]),
      .gear_num   (gpe_pkg::GEAR_W'(i + 1)),
      .valid_in   (gear_valid[i]),
      .ready_out  (gear_ready[i]),
      .data_in    (gear_data[i]),
      .valid_out  (gear_valid[i+1]),
      .ready_in   (gear_ready[i+1]),
      .data_out   (gear_data[i+1])
    );
  end

  assign gear_ready[NG]        = result.ready;
  assign result.valid          = gear_valid[NG];
  assign result.gear           = gear_data[NG].stand ? gpe_pkg::GEAR_W'(1)
                                                     : gear_data[NG].best_gear;
  assign result.measured_ratio = gear_data[NG].ratio;

  `ASSERT_IMPLIES(a_gear_range, clk, rst, result.valid,
    result.gear != '0 && result.gear <= gpe_pkg::GEAR_W'(NG))

endmodule

// ===== test/gear_position_estimator_top_test.sv =====
`timescale 1ns / 1ps

module gear_position_estimator_top_test;
  import gpe_pkg::*;

  localparam int IDX_W = $clog2(NUM_REGS);

  typedef struct packed {
    logic [GEAR_W-1:0]  gear;
    logic [RATIO_W-1:0] ratio;
  } estimate_t;

  typedef enum {CFG_RANDOM, CFG_ZERO, CFG_FULL, CFG_GEARBOX} cfg_style_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  gpe_sample_if sample_bus ();
  gpe_result_if result_bus ();

  gear_position_estimator_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_bus),
    .result  (result_bus)
  );

  // shadow copy of the register file
  logic [TIRE_W-1:0] tire_mm;
  logic [RREG_W-1:0] fdr;
  rreg_t gear_ratio [GEAR_SLOTS];

  estimate_t pending_estimates [$];
  int mismatches = 0;
  bit src_gaps = 1'b1;
  bit snk_gaps = 1'b1;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic estimate_t estimate_gear(input logic [RPM_W-1:0] rpm,
                                              input logic [KMH_W-1:0] kmh);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [31:0] err;
    logic [31:0] best_err;
    estimate_t est;
    est.gear = GEAR_W'(1);
    est.ratio = '0;
    if (kmh != 0) begin
      num = (64'(tire_mm) * 64'(rpm) * 64'(RPM_SCALE)) << FRAC_SHIFT;
      den = 64'(kmh) * 64'(fdr) * 64'(DEN_SCALE);
      quo = (den == 0) ? 64'(RATIO_MAX) : num / den;
      est.ratio = (quo > 64'(RATIO_MAX)) ? RATIO_MAX : quo[RATIO_W-1:0];
      best_err = '1;
      for (int i = 0; i < NUM_GEARS; i++) begin
        err = (32'(gear_ratio[i]) > 32'(est.ratio)) ? 32'(gear_ratio[i]) - 32'(est.ratio)
                                                    : 32'(est.ratio) - 32'(gear_ratio[i]);
        if (i == 0 || err < best_err) begin
          best_err = err;
          est.gear = GEAR_W'(i + 1);
        end
      end
    end
    return est;
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
    if (mismatches < 10)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_val, act_val);
    mismatches++;
  endfunction

  // predict at each accepted sample transfer
  always @(posedge clk) begin
    if (!rst && sample_bus.valid && sample_bus.ready)
      pending_estimates.push_back(estimate_gear(sample_bus.engine_rpm, sample_bus.speed_kmh));
  end

  always @(posedge clk) begin
    result_bus.ready <= !(snk_gaps && $urandom_range(0, 99) < 35);
  end

  always @(posedge clk) begin
    estimate_t est;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_estimates.size() == 0) begin
        note_mismatch("result with nothing pending", 64'(0), 64'(result_bus.measured_ratio));
      end else begin
        est = pending_estimates.pop_front();
        if (result_bus.gear !== est.gear)
          note_mismatch("gear", 64'(est.gear), 64'(result_bus.gear));
        if (result_bus.measured_ratio !== est.ratio)
          note_mismatch("measured_ratio", 64'(est.ratio), 64'(result_bus.measured_ratio));
      end
    end
  end

  task automatic send_sample(input logic [RPM_W-1:0] rpm, input logic [KMH_W-1:0] kmh);
    while (src_gaps && $urandom_range(0, 99) < 35) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.engine_rpm <= rpm;
    sample_bus.speed_kmh <= kmh;
    do @(posedge clk); while (!sample_bus.ready);
  endtask

  task automatic wait_for_results();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (index)
      REG_TIRE: begin
        tire_mm = value[TIRE_W-1:0];
        stored = DATA_W'(tire_mm);
      end
      REG_FDR: begin
        fdr = value[RREG_W-1:0];
        stored = DATA_W'(fdr);
      end
      default: begin
        gear_ratio[index - REG_GEAR_FIRST] = value[RREG_W-1:0];
        stored = DATA_W'(value[RREG_W-1:0]);
      end
    endcase
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored)
      note_mismatch($sformatf("readback of register %0d", index), 64'(stored), 64'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_style_t style);
    logic [DATA_W-1:0] value [NUM_REGS];
    for (int r = 0; r < NUM_REGS; r++) begin
      case (style)
        CFG_ZERO: value[r] = '0;
        CFG_FULL: value[r] = '1;
        default: begin
          value[r] = $urandom;
          if ($urandom_range(0, 7) == 0) value[r] = '0;
          else if ($urandom_range(0, 7) == 0) value[r] = '1;
        end
      endcase
    end
    if (style == CFG_GEARBOX) begin
      value[REG_TIRE] = $urandom_range(1400, 2600);
      value[REG_FDR] = $urandom_range(8000, 24000);
      value[REG_GEAR_FIRST] = $urandom_range(9000, 20000);
      for (int g = 1; g < GEAR_SLOTS; g++)
        value[REG_GEAR_FIRST + g] = value[REG_GEAR_FIRST + g - 1] * $urandom_range(55, 88) / 100;
    end
    for (int r = 0; r < NUM_REGS; r++)
      write_reg(IDX_W'(r), value[r]);
  endtask

  // about half speeds/rpms that land near a configured gear, plus standstill, extremes and random picks
  task automatic send_random_sample();
    logic [RPM_W-1:0] rpm;
    logic [KMH_W-1:0] kmh;
    logic [127:0] scaled;
    int pick;
    int g;
    pick = $urandom_range(0, 15);
    rpm = RPM_W'($urandom);
    kmh = KMH_W'($urandom);
    if (pick == 0) begin
      kmh = '0;
    end else if (pick == 1) begin
      rpm = $urandom_range(0, 1) ? '1 : '0;
      kmh = $urandom_range(0, 1) ? '1 : KMH_W'(1);
    end else if (pick < 10 && tire_mm != 0) begin
      if (kmh == 0) kmh = KMH_W'(1);
      g = $urandom_range(0, NUM_GEARS - 1);
      scaled = (128'(gear_ratio[g]) * 128'(kmh) * 128'(fdr) * 128'(DEN_SCALE))
               / ((128'(tire_mm) * 128'(RPM_SCALE)) << FRAC_SHIFT);
      scaled = scaled + 128'($urandom_range(0, 3));
      rpm = (scaled > 128'(16383)) ? '1 : scaled[RPM_W-1:0];
    end
    send_sample(rpm, kmh);
  endtask

  task automatic test_reset_defaults();
    int kmh_list [6] = '{20, 40, 60, 80, 120, 160};
    send_sample('0, '0);
    send_sample('1, '0);
    send_sample('0, KMH_W'(1));
    send_sample('1, KMH_W'(1));
    send_sample('1, '1);
    send_sample(RPM_W'(1), '1);
    foreach (kmh_list[k])
      send_sample(RPM_W'(3000), KMH_W'(kmh_list[k]));
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    load_config(CFG_ZERO);
    send_sample('1, KMH_W'(1));
    send_sample('0, '1);
    wait_for_results();
    write_reg(REG_TIRE, DATA_W'(TIRE_RESET));
    send_sample(RPM_W'(2500), KMH_W'(70));
    wait_for_results();
    load_config(CFG_FULL);
    send_sample('1, KMH_W'(1));
    send_sample('1, '1);
    send_sample('0, '1);
    wait_for_results();
  endtask

  task automatic test_gear_ties();
    logic [RATIO_W-1:0] center;
    estimate_t probe;
    write_reg(REG_TIRE, DATA_W'(TIRE_RESET));
    write_reg(REG_FDR, DATA_W'(FDR_RESET));
    probe = estimate_gear(RPM_W'(3000), KMH_W'(50));
    center = probe.ratio;
    write_reg(REG_GEAR_FIRST, '1);
    write_reg(IDX_W'(REG_GEAR_FIRST + 1), DATA_W'(center + 7));
    write_reg(IDX_W'(REG_GEAR_FIRST + 2), DATA_W'(center - 7));
    for (int g = 3; g < GEAR_SLOTS; g++)
      write_reg(IDX_W'(REG_GEAR_FIRST + g), '1);
    send_sample(RPM_W'(3000), KMH_W'(50));
    wait_for_results();
    write_reg(IDX_W'(REG_GEAR_FIRST + 4), DATA_W'(center));
    write_reg(IDX_W'(REG_GEAR_FIRST + 5), DATA_W'(center));
    send_sample(RPM_W'(3000), KMH_W'(50));
    wait_for_results();
  endtask

  task automatic test_random_configs();
    cfg_style_t styles [6] = '{CFG_GEARBOX, CFG_RANDOM, CFG_GEARBOX, CFG_FULL,
                               CFG_GEARBOX, CFG_RANDOM};
    foreach (styles[p]) begin
      load_config(styles[p]);
      for (int n = 0; n < 55; n++) begin
        send_random_sample();
        // sender holds off until the pipe is empty, then resumes
        if (p == 2 && n == 27) wait_for_results();
      end
      wait_for_results();
    end
  endtask

  task automatic test_no_idle_stretch();
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    load_config(CFG_GEARBOX);
    repeat (120) send_random_sample();
    wait_for_results();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.engine_rpm = '0;
    sample_bus.speed_kmh = '0;
    result_bus.ready = 1'b0;
    tire_mm = TIRE_RESET;
    fdr = FDR_RESET;
    for (int g = 0; g < GEAR_SLOTS; g++)
      gear_ratio[g] = GEAR_RESET[g];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_gear_ties();
    test_random_configs();
    test_no_idle_stretch();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gpe_pkg.sv
rtl/gpe_if.sv
rtl/gpe_div_cell.sv
rtl/gpe_gear_cell.sv
rtl/gear_position_estimator_top.sv
test/gear_position_estimator_top_test.sv
